// ===== hdl/ssta_pkg.sv =====
// Package: shared constants, types and codes of the sorted sparse term accumulator.
package ssta_pkg;

	localparam int MAX_TERMS = 64;
	localparam int EXP_BITS  = 16;
	localparam int COEF_BITS = 32;
	localparam int IDX_W     = $clog2(MAX_TERMS);
	localparam int COUNT_W   = $clog2(MAX_TERMS + 1);

	// Result status codes
	typedef enum logic [2:0] {
		ST_INSERTED  = 3'd0,
		ST_MERGED    = 3'd1,
		ST_CANCELLED = 3'd2,
		ST_DROPPED   = 3'd3,
		ST_ZERO      = 3'd4,
		ST_READ_OK   = 3'd5,
		ST_READ_OOR  = 3'd6
	} status_t;

	// Item opcodes
	typedef enum logic {
		OP_ADD  = 1'b0,
		OP_READ = 1'b1
	} opcode_t;

	// What the cell row does in an update cycle
	typedef enum logic [1:0] {
		UPD_NONE  = 2'd0,
		UPD_INS   = 2'd1,
		UPD_DEL   = 2'd2,
		UPD_WRITE = 2'd3
	} upd_kind_t;

	// Sequencer states
	typedef enum logic [1:0] {
		S_IDLE,
		S_PICK,
		S_UPD
	} state_t;

	// One stored term
	typedef struct packed {
		logic [COEF_BITS-1:0] coef;
		logic [EXP_BITS-1:0]  expo;
	} term_t;

	// Control broadcast from the sequencer to every cell
	typedef struct packed {
		logic                 cmp;
		logic                 rd;
		logic [IDX_W-1:0]     rd_idx;
		logic [EXP_BITS-1:0]  expo;
		logic [COUNT_W-1:0]   count;
		upd_kind_t            kind;
		logic [COEF_BITS-1:0] coef;
	} bcast_t;

	// Flags a cell reports back after a compare
	typedef struct packed {
		logic gt;
		logic eq;
		logic sel;
	} cell_flags_t;

endpackage

// ===== hdl/ssta_req_if.sv =====
// Interface: request channel carrying add and read words.
interface ssta_req_if;
	logic                               valid;
	logic                               ready;
	logic                               opcode;
	logic [ssta_pkg::COEF_BITS-1:0]     term_coefficient;
	logic [15:0]                        term_exponent;
	logic [ssta_pkg::IDX_W-1:0]         read_index;

	modport source (output valid, opcode, term_coefficient, term_exponent, read_index,
		input ready);
	modport sink (input valid, opcode, term_coefficient, term_exponent, read_index,
		output ready);
endinterface

// ===== hdl/ssta_rsp_if.sv =====
// Interface: response channel carrying one result word per request.
interface ssta_rsp_if;
	logic                               valid;
	logic                               ready;
	logic [2:0]                         status;
	logic [ssta_pkg::COUNT_W-1:0]       term_count;
	logic [ssta_pkg::COEF_BITS-1:0]     out_coefficient;
	logic [15:0]                        out_exponent;
	logic                               saturated;

	modport source (output valid, status, term_count, out_coefficient, out_exponent,
		saturated, input ready);
	modport sink (input valid, status, term_count, out_coefficient, out_exponent,
		saturated, output ready);
endinterface

// ===== hdl/sorted_sparse_term_accumulator_core.sv =====
// Top level: sequencer, result register and the row of term cells.
// Steps: compare at accept, select, then update; the result word is registered at update.
// The block takes no new request until update is done; the next request is taken in the
// cycle after update.
// A pending result word does not block a new request; update waits while the result stalls.
// Reset clears the term count and the handshake state; table contents stay undefined
// until written and are never read at or above the count.
module sorted_sparse_term_accumulator_core (
	input  logic        clk,
	input  logic        arst_n,
	ssta_req_if.sink    req,
	ssta_rsp_if.source  rsp
);

	localparam int N = ssta_pkg::MAX_TERMS;

	ssta_pkg::state_t      state_q, state_nx;
	ssta_pkg::bcast_t      bcast;
	ssta_pkg::term_t       cell_term  [N];
	ssta_pkg::cell_flags_t cell_flags [N];

	logic [ssta_pkg::COUNT_W-1:0]   count_q;
	logic                           op_q;
	logic [ssta_pkg::COEF_BITS-1:0] coef_q;
	logic [ssta_pkg::EXP_BITS-1:0]  expo_q;
	logic [ssta_pkg::IDX_W-1:0]     idx_q;

	ssta_pkg::term_t pick_s2;
	logic            hit_s2;
	ssta_pkg::term_t pick_or;
	logic            hit_or;

	logic                           accept;
	logic                           out_free;
	logic                           do_upd;
	logic [ssta_pkg::COEF_BITS:0]   sum;
	logic                           ovf;
	logic [ssta_pkg::COEF_BITS-1:0] sum_sat;

	ssta_pkg::upd_kind_t            kind;
	ssta_pkg::status_t              st;
	logic [ssta_pkg::COUNT_W-1:0]   count_nx;
	logic [ssta_pkg::COEF_BITS-1:0] res_coef;
	logic [ssta_pkg::EXP_BITS-1:0]  res_expo;
	logic                           res_sat;

	logic                           rsp_valid_q;
	ssta_pkg::status_t              rsp_status_q;
	logic [ssta_pkg::COUNT_W-1:0]   rsp_count_q;
	logic [ssta_pkg::COEF_BITS-1:0] rsp_coef_q;
	logic [ssta_pkg::EXP_BITS-1:0]  rsp_expo_q;
	logic                           rsp_sat_q;

	// Handshake
	assign req.ready = (state_q == ssta_pkg::S_IDLE);
	assign accept    = req.valid && req.ready;
	assign out_free  = !rsp_valid_q || rsp.ready;
	assign do_upd    = (state_q == ssta_pkg::S_UPD) && out_free;

	// Next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			ssta_pkg::S_IDLE: begin
				if (accept) begin
					state_nx = ssta_pkg::S_PICK;
				end
			end
			ssta_pkg::S_PICK: begin
				state_nx = ssta_pkg::S_UPD;
			end
			ssta_pkg::S_UPD: begin
				if (out_free) begin
					state_nx = ssta_pkg::S_IDLE;
				end
			end
			default: begin
				state_nx = ssta_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ssta_pkg::S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// Hold the accepted word
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= req.opcode;
			coef_q <= req.term_coefficient;
			expo_q <= ssta_pkg::EXP_BITS'(req.term_exponent);
			idx_q  <= req.read_index;
		end
	end

	// Gather the selected term from the row (one cell is selected at most)
	always_comb begin
		pick_or = '0;
		hit_or  = 1'b0;
		for (int i = 0; i < N; i++) begin
			if (cell_flags[i].sel) begin
				pick_or = pick_or | cell_term[i];
			end
			hit_or = hit_or | cell_flags[i].eq;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ssta_pkg::S_PICK) begin
			pick_s2 <= pick_or;
			hit_s2  <= hit_or;
		end
	end

	// Saturating merge sum
	assign sum     = {coef_q[ssta_pkg::COEF_BITS-1], coef_q}
		+ {pick_s2.coef[ssta_pkg::COEF_BITS-1], pick_s2.coef};
	assign ovf     = sum[ssta_pkg::COEF_BITS] != sum[ssta_pkg::COEF_BITS-1];
	assign sum_sat = ovf
		? {sum[ssta_pkg::COEF_BITS], {(ssta_pkg::COEF_BITS-1){!sum[ssta_pkg::COEF_BITS]}}}
		: sum[ssta_pkg::COEF_BITS-1:0];

	// Decide the outcome of the item
	always_comb begin
		kind     = ssta_pkg::UPD_NONE;
		st       = ssta_pkg::ST_ZERO;
		count_nx = count_q;
		res_coef = '0;
		res_expo = expo_q;
		res_sat  = 1'b0;
		if (op_q == ssta_pkg::OP_READ) begin
			if ({1'b0, idx_q} < count_q) begin
				st       = ssta_pkg::ST_READ_OK;
				res_coef = pick_s2.coef;
				res_expo = pick_s2.expo;
			end else begin
				st       = ssta_pkg::ST_READ_OOR;
				res_expo = '0;
			end
		end else if (coef_q == '0) begin
			st = ssta_pkg::ST_ZERO;
		end else if (hit_s2) begin
			if (sum == '0) begin
				kind     = ssta_pkg::UPD_DEL;
				st       = ssta_pkg::ST_CANCELLED;
				count_nx = count_q - ssta_pkg::COUNT_W'(1);
			end else begin
				kind     = ssta_pkg::UPD_WRITE;
				st       = ssta_pkg::ST_MERGED;
				res_coef = sum_sat;
				res_sat  = ovf;
			end
		end else if (count_q >= ssta_pkg::COUNT_W'(N)) begin
			st       = ssta_pkg::ST_DROPPED;
			res_coef = coef_q;
		end else begin
			kind     = ssta_pkg::UPD_INS;
			st       = ssta_pkg::ST_INSERTED;
			count_nx = count_q + ssta_pkg::COUNT_W'(1);
			res_coef = coef_q;
		end
	end

	// Broadcast to the cells: compare on accept, shift or write on update
	always_comb begin
		bcast.cmp    = accept;
		bcast.rd     = (state_q == ssta_pkg::S_IDLE) ? req.opcode : op_q;
		bcast.rd_idx = req.read_index;
		bcast.expo   = (state_q == ssta_pkg::S_IDLE) ? ssta_pkg::EXP_BITS'(req.term_exponent)
			: expo_q;
		bcast.count  = count_q;
		bcast.kind   = do_upd ? kind : ssta_pkg::UPD_NONE;
		bcast.coef   = (kind == ssta_pkg::UPD_WRITE) ? sum_sat : coef_q;
	end

	// Term count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (do_upd) begin
			count_q <= count_nx;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (do_upd) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (do_upd) begin
			rsp_status_q <= st;
			rsp_count_q  <= count_nx;
			rsp_coef_q   <= res_coef;
			rsp_expo_q   <= res_expo;
			rsp_sat_q    <= res_sat;
		end
	end

	assign rsp.valid           = rsp_valid_q;
	assign rsp.status          = rsp_status_q;
	assign rsp.term_count      = rsp_count_q;
	assign rsp.out_coefficient = rsp_coef_q;
	assign rsp.out_exponent    = 16'(rsp_expo_q);
	assign rsp.saturated       = rsp_sat_q;

	// Row of cells, each linked to its neighbors
	for (genvar i = 0; i < N; i++) begin : g_cell
		ssta_pkg::term_t left_term;
		ssta_pkg::term_t right_term;
		logic            left_gt;

		if (i == 0) begin : g_first
			assign left_term = '0;
			assign left_gt   = 1'b1;
		end else begin : g_mid
			assign left_term = cell_term[i-1];
			assign left_gt   = cell_flags[i-1].gt;
		end

		if (i == N - 1) begin : g_last
			assign right_term = '0;
		end else begin : g_inner
			assign right_term = cell_term[i+1];
		end

		ssta_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.idx        (ssta_pkg::IDX_W'(i)),
			.bcast      (bcast),
			.left_term  (left_term),
			.right_term (right_term),
			.left_gt    (left_gt),
			.term       (cell_term[i]),
			.flags      (cell_flags[i])
		);
	end

endmodule

// ===== hdl/ssta_cell.sv =====
// Cell: holds one table term, compares it against the item and shifts with its neighbors.
module ssta_cell (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [ssta_pkg::IDX_W-1:0]   idx,
	input  ssta_pkg::bcast_t             bcast,
	input  ssta_pkg::term_t              left_term,
	input  ssta_pkg::term_t              right_term,
	input  logic                         left_gt,
	output ssta_pkg::term_t              term,
	output ssta_pkg::cell_flags_t        flags
);

	ssta_pkg::term_t       term_q;
	ssta_pkg::cell_flags_t flags_q;
	logic                  live;

	// Entry is part of the table when its position is below the count
	assign live = {1'b0, idx} < bcast.count;

	// Compare against the incoming word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q <= '0;
		end else if (bcast.cmp) begin
			flags_q.gt  <= live && (term_q.expo > bcast.expo);
			flags_q.eq  <= live && (term_q.expo == bcast.expo);
			flags_q.sel <= bcast.rd ? (idx == bcast.rd_idx)
				: (live && (term_q.expo == bcast.expo));
		end
	end

	// Shift in from a neighbor, take the new term, or write the merged sum
	always_ff @(posedge clk) begin
		case (bcast.kind)
			ssta_pkg::UPD_INS: begin
				if (!left_gt) begin
					term_q <= left_term;
				end else if (!flags_q.gt) begin
					term_q <= '{coef: bcast.coef, expo: bcast.expo};
				end
			end
			ssta_pkg::UPD_DEL: begin
				if (!flags_q.gt) begin
					term_q <= right_term;
				end
			end
			ssta_pkg::UPD_WRITE: begin
				if (flags_q.eq) begin
					term_q.coef <= bcast.coef;
				end
			end
			default: begin
			end
		endcase
	end

	assign term  = term_q;
	assign flags = flags_q;

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps
// Testbench: streams add and read words into the sparse term accumulator and checks every result.
module testbench;

	localparam int LATENCY_CYCLES = 3;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int ROUND_WORDS    = 250;
	localparam int RANDOM_ROUNDS  = 8;
	localparam int MAX_PRINTED    = 40;
	localparam longint COEF_MAX   = (longint'(1) <<< 31) - 1;
	localparam longint COEF_MIN   = -(longint'(1) <<< 31);

	// One expected result word
	typedef struct {
		ssta_pkg::status_t              status;
		logic [ssta_pkg::COUNT_W-1:0]   count;
		logic [ssta_pkg::COEF_BITS-1:0] coef;
		logic [15:0]                    expo;
		logic                           sat;
	} result_word_t;

	logic clk = 1'b0;
	logic arst_n;

	ssta_req_if req_if();
	ssta_rsp_if rsp_if();

	sorted_sparse_term_accumulator_core i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	// Mirror of the polynomial held by the block
	logic [ssta_pkg::COEF_BITS-1:0] coef_tbl [ssta_pkg::MAX_TERMS];
	logic [ssta_pkg::EXP_BITS-1:0]  expo_tbl [ssta_pkg::MAX_TERMS];
	int                             held_terms = 0;

	result_word_t pending_results [$];

	int status_seen [8] = '{default: 0};
	int words_sent      = 0;
	int words_checked   = 0;
	int mismatches      = 0;
	int clamped_merges  = 0;
	int stall_left      = 0;
	bit idling_on       = 0;

	always #4 clk = ~clk;

	// Apply one word to the mirrored polynomial and return the result it should produce
	function automatic result_word_t apply_word(ssta_pkg::opcode_t op,
			logic [ssta_pkg::COEF_BITS-1:0] c, logic [15:0] e,
			logic [ssta_pkg::IDX_W-1:0] idx);
		result_word_t w;
		int pos;
		int i;
		longint sum;
		w.sat = 1'b0;
		if (op == ssta_pkg::OP_READ) begin
			if (idx < held_terms) begin
				w.status = ssta_pkg::ST_READ_OK;
				w.coef   = coef_tbl[idx];
				w.expo   = expo_tbl[idx];
			end else begin
				w.status = ssta_pkg::ST_READ_OOR;
				w.coef   = '0;
				w.expo   = '0;
			end
		end else if (c == '0) begin
			w.status = ssta_pkg::ST_ZERO;
			w.coef   = '0;
			w.expo   = e;
		end else begin
			// find the first term whose exponent is not above the new one
			pos = 0;
			while (pos < held_terms && expo_tbl[pos] > e)
				pos++;
			w.expo = e;
			if (pos < held_terms && expo_tbl[pos] == e) begin
				sum = longint'($signed(c)) + longint'($signed(coef_tbl[pos]));
				if (sum > COEF_MAX) begin
					sum   = COEF_MAX;
					w.sat = 1'b1;
				end else if (sum < COEF_MIN) begin
					sum   = COEF_MIN;
					w.sat = 1'b1;
				end
				if (sum == 0) begin
					// close up the gap left by the cancelled term
					for (i = pos; i + 1 < held_terms; i++) begin
						coef_tbl[i] = coef_tbl[i + 1];
						expo_tbl[i] = expo_tbl[i + 1];
					end
					held_terms--;
					w.status = ssta_pkg::ST_CANCELLED;
					w.coef   = '0;
				end else begin
					coef_tbl[pos] = sum[ssta_pkg::COEF_BITS-1:0];
					w.status      = ssta_pkg::ST_MERGED;
					w.coef        = sum[ssta_pkg::COEF_BITS-1:0];
				end
			end else if (held_terms >= ssta_pkg::MAX_TERMS) begin
				w.status = ssta_pkg::ST_DROPPED;
				w.coef   = c;
			end else begin
				// open a slot at the ordered position
				for (i = held_terms; i > pos; i--) begin
					coef_tbl[i] = coef_tbl[i - 1];
					expo_tbl[i] = expo_tbl[i - 1];
				end
				coef_tbl[pos] = c;
				expo_tbl[pos] = e;
				held_terms++;
				w.status = ssta_pkg::ST_INSERTED;
				w.coef   = c;
			end
		end
		w.count = ssta_pkg::COUNT_W'(held_terms);
		return w;
	endfunction

	function automatic int find_term(logic [15:0] e);
		int i;
		for (i = 0; i < held_terms; i++)
			if (expo_tbl[i] == e)
				return i;
		return -1;
	endfunction

	// Nonzero coefficient: small values, extremes and full-width noise
	function automatic logic [ssta_pkg::COEF_BITS-1:0] rand_coef();
		logic [ssta_pkg::COEF_BITS-1:0] c;
		case ($urandom_range(0, 3))
			0: c = ssta_pkg::COEF_BITS'($urandom_range(1, 1000));
			1: c = ssta_pkg::COEF_BITS'(-int'($urandom_range(1, 1000)));
			2: c = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
			default: c = $urandom();
		endcase
		if (c == '0)
			c = 32'd1;
		return c;
	endfunction

	function automatic logic [15:0] fresh_exponent();
		logic [15:0] e;
		do
			e = 16'($urandom());
		while (find_term(e) >= 0);
		return e;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		mismatches++;
		if (mismatches <= MAX_PRINTED)
			$display("%0t ns: %s mismatch on result word %0d: got %h, expected %h",
				$time, what, words_checked, got, want);
	endtask

	// Send one word, after a random gap while idling is on, and record what it should return
	task automatic send_word(ssta_pkg::opcode_t op, logic [ssta_pkg::COEF_BITS-1:0] c,
			logic [15:0] e, logic [ssta_pkg::IDX_W-1:0] idx);
		int gap;
		result_word_t w;
		gap = idling_on ? $urandom_range(0, 12) : 0;
		if (gap > 0) begin
			req_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_if.valid            <= 1'b1;
		req_if.opcode           <= op;
		req_if.term_coefficient <= c;
		req_if.term_exponent    <= e;
		req_if.read_index       <= idx;
		@(posedge clk);
		while (!req_if.ready)
			@(posedge clk);
		w = apply_word(op, c, e, idx);
		pending_results.insert(pending_results.size(), w);
		status_seen[w.status]++;
		if (w.sat)
			clamped_merges++;
		words_sent++;
	endtask

	// Hold the sender until every result is back, then let the block settle
	task automatic wait_for_results();
		req_if.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (LATENCY_CYCLES) @(posedge clk);
	endtask

	task automatic test_directed_cases();
		int i;
		idling_on = 0;
		// reads of an empty table
		send_word(ssta_pkg::OP_READ, '0, '0, 6'd0);
		send_word(ssta_pkg::OP_READ, '0, '0, 6'd63);
		// zero coefficient is ignored
		send_word(ssta_pkg::OP_ADD, 32'd0, 16'hFFFF, '0);
		// inserts at top, bottom and middle
		send_word(ssta_pkg::OP_ADD, 32'd5, 16'hFFFF, 6'h3F);
		send_word(ssta_pkg::OP_ADD, 32'hFFFF_FFF9, 16'h0000, '0);
		send_word(ssta_pkg::OP_ADD, 32'h7FFF_FFFF, 16'h8000, '0);
		// clamp a merge high, then low, then two minimums
		send_word(ssta_pkg::OP_ADD, 32'd1, 16'h8000, '0);
		send_word(ssta_pkg::OP_ADD, 32'h8000_0000, 16'h1234, '0);
		send_word(ssta_pkg::OP_ADD, 32'hFFFF_FFFF, 16'h1234, '0);
		send_word(ssta_pkg::OP_ADD, 32'h8000_0000, 16'h1234, '0);
		// cancel the top and the bottom term
		send_word(ssta_pkg::OP_ADD, 32'hFFFF_FFFB, 16'hFFFF, '0);
		send_word(ssta_pkg::OP_ADD, 32'd7, 16'h0000, '0);
		// plain merge without clamping
		send_word(ssta_pkg::OP_ADD, 32'd3, 16'h0100, '0);
		send_word(ssta_pkg::OP_ADD, 32'd4, 16'h0100, '0);
		// cancel a middle term
		send_word(ssta_pkg::OP_ADD, 32'h8000_0001, 16'h8000, '0);
		// alternating bit patterns
		send_word(ssta_pkg::OP_ADD, 32'h5555_5555, 16'hAAAA, 6'h2A);
		send_word(ssta_pkg::OP_ADD, 32'hAAAA_AAAA, 16'h5555, 6'h15);
		// read every held term and one past the end
		for (i = 0; i <= 4; i++)
			send_word(ssta_pkg::OP_READ, 32'hFFFF_FFFF, 16'hFFFF, ssta_pkg::IDX_W'(i));
		send_word(ssta_pkg::OP_READ, '0, '0, 6'h2A);
		wait_for_results();
	endtask

	task automatic test_table_full();
		int p;
		idling_on = 1;
		// fill every slot with distinct exponents
		while (held_terms < ssta_pkg::MAX_TERMS)
			send_word(ssta_pkg::OP_ADD, rand_coef(), fresh_exponent(),
				ssta_pkg::IDX_W'($urandom()));
		// a new exponent is dropped while the table is full
		send_word(ssta_pkg::OP_ADD, rand_coef(), fresh_exponent(), '0);
		send_word(ssta_pkg::OP_ADD, 32'h8000_0000, fresh_exponent(), 6'h3F);
		send_word(ssta_pkg::OP_READ, '0, '0, 6'd63);
		// merge and cancel still work on a full table
		p = $urandom_range(0, held_terms - 1);
		send_word(ssta_pkg::OP_ADD, rand_coef(), expo_tbl[p], '0);
		p = $urandom_range(0, held_terms - 1);
		send_word(ssta_pkg::OP_ADD, -coef_tbl[p], expo_tbl[p], '0);
		send_word(ssta_pkg::OP_ADD, rand_coef(), fresh_exponent(), '0);
		// empty the table by cancels; a minimum coefficient is first raised by one
		while (held_terms > 0) begin
			p = $urandom_range(0, held_terms - 1);
			if (coef_tbl[p] == 32'h8000_0000)
				send_word(ssta_pkg::OP_ADD, 32'd1, expo_tbl[p], '0);
			else
				send_word(ssta_pkg::OP_ADD, -coef_tbl[p], expo_tbl[p],
					ssta_pkg::IDX_W'($urandom()));
		end
		send_word(ssta_pkg::OP_READ, '0, '0, 6'd0);
		wait_for_results();
	endtask

	// Pick one random word: reads, zeros, touches of held terms and new terms
	task automatic send_random_word(bit grow);
		int r;
		int p;
		int sub;
		logic [ssta_pkg::COEF_BITS-1:0] c;
		logic [15:0] e;
		r = $urandom_range(0, 99);
		if (r < 12) begin
			if (held_terms > 0 && $urandom_range(0, 1))
				send_word(ssta_pkg::OP_READ, $urandom(), 16'($urandom()),
					ssta_pkg::IDX_W'($urandom_range(0, held_terms - 1)));
			else
				send_word(ssta_pkg::OP_READ, $urandom(), 16'($urandom()),
					ssta_pkg::IDX_W'($urandom_range(0, 63)));
		end else if (r < 17) begin
			send_word(ssta_pkg::OP_ADD, '0, 16'($urandom()), ssta_pkg::IDX_W'($urandom()));
		end else if (held_terms > 0 && r < (grow ? 40 : 75)) begin
			p   = $urandom_range(0, held_terms - 1);
			sub = $urandom_range(0, 5);
			if (sub < (grow ? 1 : 4))
				c = -coef_tbl[p];
			else if (sub == 4)
				c = coef_tbl[p][ssta_pkg::COEF_BITS-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
			else
				c = rand_coef();
			send_word(ssta_pkg::OP_ADD, c, expo_tbl[p], ssta_pkg::IDX_W'($urandom()));
		end else begin
			e = ($urandom_range(0, 3) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 95));
			send_word(ssta_pkg::OP_ADD, rand_coef(), e, ssta_pkg::IDX_W'($urandom()));
		end
	endtask

	task automatic test_random_mix();
		int round;
		for (round = 0; round < RANDOM_ROUNDS; round++) begin
			idling_on = (round % 4 != 1);
			repeat (ROUND_WORDS) send_random_word(round % 2 == 0);
			wait_for_results();
		end
	endtask

	// Drive result ready with a random stall after each accepted word while idling is on
	always @(posedge clk) begin
		if (rsp_if.valid && rsp_if.ready)
			stall_left = idling_on ? $urandom_range(0, 12) : 0;
		if (stall_left > 0) begin
			stall_left--;
			rsp_if.ready <= 1'b0;
		end else begin
			rsp_if.ready <= 1'b1;
		end
	end

	// Compare each accepted result word with the oldest expectation
	always @(posedge clk) begin : check_results
		result_word_t want;
		if (arst_n && rsp_if.valid && rsp_if.ready) begin
			words_checked++;
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected word", 32'(rsp_if.status), '0);
			end else begin
				want = pending_results[0];
				pending_results.delete(0);
				if (rsp_if.status !== want.status)
					report_mismatch("status", 32'(rsp_if.status), 32'(want.status));
				if (rsp_if.term_count !== want.count)
					report_mismatch("term_count", 32'(rsp_if.term_count), 32'(want.count));
				if (rsp_if.out_coefficient !== want.coef)
					report_mismatch("out_coefficient", rsp_if.out_coefficient, want.coef);
				if (rsp_if.out_exponent !== want.expo)
					report_mismatch("out_exponent", 32'(rsp_if.out_exponent), 32'(want.expo));
				if (rsp_if.saturated !== want.sat)
					report_mismatch("saturated", 32'(rsp_if.saturated), 32'(want.sat));
			end
		end
	end

	// End the run when no word moves on either channel for too long
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("%0t ns: no word moved for %0d cycles, %0d results outstanding",
			$time, WATCHDOG_LIMIT, pending_results.size());
		$display("FAIL sorted_sparse_term_accumulator_core");
		$finish;
	end

	initial begin
		arst_n                  = 1'b0;
		req_if.valid            = 1'b0;
		req_if.opcode           = ssta_pkg::OP_ADD;
		req_if.term_coefficient = '0;
		req_if.term_exponent    = '0;
		req_if.read_index       = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_cases();
		test_table_full();
		test_random_mix();

		$display("Covered %0d words: %0d inserts, %0d merges (%0d clamped), %0d cancels, %0d drops",
			words_sent, status_seen[ssta_pkg::ST_INSERTED], status_seen[ssta_pkg::ST_MERGED],
			clamped_merges, status_seen[ssta_pkg::ST_CANCELLED],
			status_seen[ssta_pkg::ST_DROPPED]);
		$display("%0d zero adds, %0d reads in range, %0d past the end; %0d checked, %0d mismatches",
			status_seen[ssta_pkg::ST_ZERO], status_seen[ssta_pkg::ST_READ_OK],
			status_seen[ssta_pkg::ST_READ_OOR], words_checked, mismatches);
		if (mismatches == 0 && pending_results.size() == 0)
			$display("PASS sorted_sparse_term_accumulator_core");
		else
			$display("FAIL sorted_sparse_term_accumulator_core");
		$finish;
	end

endmodule

// ===== filelist.f =====
hdl/ssta_pkg.sv
hdl/ssta_req_if.sv
hdl/ssta_rsp_if.sv
hdl/ssta_cell.sv
hdl/sorted_sparse_term_accumulator_core.sv
sim/testbench.sv
